### rtl/sia_pkg.sv
package sia_pkg;

    localparam int COORD_W     = 24;
    localparam int VEL_W       = 32;
    localparam int CFG_W       = 17;
    localparam int LEN_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_W-1:0] Q16_ONE        = 17'h10000;
    localparam logic [CFG_W-1:0] MASS_RECIP_RST = 17'd16384;
    localparam logic [CFG_W-1:0] DRAG_KEEP_RST  = 17'd58982;
    localparam logic [LEN_W-1:0] WINDOW_LEN_RST = 5'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_MASS_RECIP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAG_KEEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd2;

    localparam logic REQ_START = 1'b0;

    typedef logic signed [COORD_W-1:0] sia_coord_t;

    typedef enum logic {
        CMD_START,
        CMD_POINT
    } sia_cmd_t;

    typedef struct packed {
        logic       req_type;
        sia_coord_t pt_x;
        sia_coord_t pt_y;
    } sia_in_t;

    typedef struct packed {
        sia_coord_t out_x;
        sia_coord_t out_y;
    } sia_out_t;

    typedef struct packed {
        sia_cmd_t   cmd;
        sia_coord_t pt_x;
        sia_coord_t pt_y;
    } sia_item_t;

    // effective (already limited to 1.0) gains
    typedef struct packed {
        logic [CFG_W-1:0] mass_recip;
        logic [CFG_W-1:0] drag_keep;
    } sia_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_ADD_V,
        ST_MUL_K,
        ST_UPD,
        ST_EVICT_CHK,
        ST_EVICT_SUB,
        ST_PUSH,
        ST_DIV_SETUP,
        ST_DIV,
        ST_DONE
    } sia_state_t;

endpackage

### rtl/sia_ram.sv
module sia_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/sia_fifo.sv
module sia_fifo
    import sia_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  sia_item_t push_item,
    output logic      pop_valid,
    input  logic      pop_ready,
    output sia_item_t pop_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    sia_item_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

### rtl/sia_front.sv
module sia_front
    import sia_pkg::*;
#(
    parameter int WINDOW_MAX = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]               cfg_index,
    input  logic [CFG_W-1:0]                   cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  sia_in_t                            in_data,
    output logic                               push_valid,
    input  logic                               push_ready,
    output sia_item_t                          push_item,
    output sia_cfg_t                           cfg,
    output logic [$clog2(WINDOW_MAX + 1)-1:0]  win_len
);

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    logic [CFG_W-1:0] mass_recip_reg;
    logic [CFG_W-1:0] drag_keep_reg;
    logic [LEN_W-1:0] window_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_recip_reg <= MASS_RECIP_RST;
            drag_keep_reg  <= DRAG_KEEP_RST;
            window_len_reg <= WINDOW_LEN_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MASS_RECIP: mass_recip_reg <= cfg_data;
                CFG_DRAG_KEEP:  drag_keep_reg  <= cfg_data;
                CFG_WINDOW_LEN: window_len_reg <= cfg_data[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    // gains above one act as one, window length limited to 1..WINDOW_MAX
    always_comb
    begin
        cfg.mass_recip = (mass_recip_reg > Q16_ONE) ? Q16_ONE : mass_recip_reg;
        cfg.drag_keep  = (drag_keep_reg > Q16_ONE) ? Q16_ONE : drag_keep_reg;
        if (window_len_reg == '0)
        begin
            win_len = CNT_W'(1);
        end
        else if (int'(window_len_reg) > WINDOW_MAX)
        begin
            win_len = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            win_len = CNT_W'(window_len_reg);
        end
    end

    always_comb
    begin
        push_item.cmd  = (in_data.req_type == REQ_START) ? CMD_START : CMD_POINT;
        push_item.pt_x = in_data.pt_x;
        push_item.pt_y = in_data.pt_y;
    end

    assign push_valid = in_valid;
    assign in_ready   = push_ready;

endmodule

### rtl/sia_back.sv
module sia_back
    import sia_pkg::*;
#(
    parameter int WINDOW_MAX = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  sia_item_t                          item,
    input  sia_cfg_t                           cfg,
    input  logic [$clog2(WINDOW_MAX + 1)-1:0]  win_len,
    output logic                               out_valid,
    input  logic                               out_ready,
    output sia_out_t                           out_data
);

    localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int SLOT_W = CNT_W + 1;
    localparam int SUM_W  = COORD_W + $clog2(WINDOW_MAX);
    localparam int DCNT_W = $clog2(SUM_W + 1);

    sia_state_t state_reg;
    sia_state_t state_next;

    // control state
    logic signed [COORD_W-1:0] pos_reg [2];
    logic signed [VEL_W-1:0]   vel_reg [2];
    logic signed [SUM_W-1:0]   sum_reg [2];
    logic [CNT_W-1:0]          fill_reg;
    logic [IDX_W-1:0]          head_reg;
    logic [DCNT_W-1:0]         div_cnt_reg;
    logic                      start_reg;
    logic                      out_valid_reg;

    // datapath registers
    logic signed [COORD_W-1:0] pt_reg     [2];
    logic [41:0]               prod_a_reg [2];
    logic [32:0]               mag_b_reg  [2];
    logic [49:0]               prod_k_reg [2];
    logic                      neg_reg    [2];
    logic [SUM_W-1:0]          dq_reg     [2];
    logic [CNT_W-1:0]          rem_reg    [2];
    sia_out_t                  out_data_reg;

    // lane arithmetic
    logic signed [COORD_W:0]   diff_a  [2];
    logic [COORD_W:0]          mag_a   [2];
    logic [41:0]               rnd_a   [2];
    logic signed [32:0]        acc     [2];
    logic signed [32:0]        sum_v   [2];
    logic [32:0]               mag_b   [2];
    logic [49:0]               rnd_k   [2];
    logic signed [34:0]        vel_r   [2];
    logic signed [VEL_W-1:0]   vel_new [2];
    logic signed [32:0]        pos_s   [2];
    logic signed [COORD_W-1:0] pos_new [2];
    logic signed [COORD_W-1:0] rd_crd  [2];
    logic [SUM_W-1:0]          sum_mag [2];
    logic [CNT_W:0]            rem_sh  [2];
    logic                      q_bit   [2];
    logic [SUM_W-1:0]          quo     [2];

    logic [SLOT_W-1:0]         slot_sum;
    logic [SLOT_W-1:0]         slot;
    logic                      need_evict;
    logic                      out_free;
    logic                      ram_we;
    logic                      ram_re;
    logic [2*COORD_W-1:0]      ram_rdata;

    assign need_evict = (fill_reg >= win_len);
    assign out_free   = !out_valid_reg || out_ready;
    assign slot_sum   = SLOT_W'(head_reg) + SLOT_W'(fill_reg);
    assign slot       = (slot_sum >= SLOT_W'(WINDOW_MAX)) ? slot_sum - SLOT_W'(WINDOW_MAX)
                                                         : slot_sum;
    assign rd_crd[0]  = ram_rdata[2*COORD_W-1:COORD_W];
    assign rd_crd[1]  = ram_rdata[COORD_W-1:0];

    sia_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (WINDOW_MAX)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot[IDX_W-1:0]),
        .wdata ({pos_reg[0], pos_reg[1]}),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            // acceleration magnitude, sign kept apart for symmetric rounding
            diff_a[l] = {pt_reg[l][COORD_W-1], pt_reg[l]} - {pos_reg[l][COORD_W-1], pos_reg[l]};
            mag_a[l]  = diff_a[l][COORD_W] ? (~diff_a[l] + 1'b1) : diff_a[l];

            rnd_a[l]  = prod_a_reg[l] + 42'd32768;
            acc[l]    = neg_reg[l] ? -$signed({7'b0, rnd_a[l][41:16]})
                                   :  $signed({7'b0, rnd_a[l][41:16]});
            sum_v[l]  = {vel_reg[l][VEL_W-1], vel_reg[l]} + acc[l];
            mag_b[l]  = sum_v[l][32] ? (~sum_v[l] + 1'b1) : sum_v[l];

            rnd_k[l]  = prod_k_reg[l] + 50'd32768;
            vel_r[l]  = neg_reg[l] ? -$signed({1'b0, rnd_k[l][49:16]})
                                   :  $signed({1'b0, rnd_k[l][49:16]});
            if (vel_r[l][34:31] == 4'b0000 || vel_r[l][34:31] == 4'b1111)
            begin
                vel_new[l] = vel_r[l][VEL_W-1:0];
            end
            else
            begin
                vel_new[l] = vel_r[l][34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end

            pos_s[l] = 33'(pos_reg[l]) + 33'(vel_new[l]);
            if (pos_s[l][32:23] == '0 || pos_s[l][32:23] == '1)
            begin
                pos_new[l] = pos_s[l][COORD_W-1:0];
            end
            else
            begin
                pos_new[l] = pos_s[l][32] ? 24'sh80_0000 : 24'sh7F_FFFF;
            end

            sum_mag[l] = sum_reg[l][SUM_W-1] ? (~sum_reg[l] + 1'b1) : sum_reg[l];
            rem_sh[l]  = {rem_reg[l], dq_reg[l][SUM_W-1]};
            q_bit[l]   = (rem_sh[l] >= {1'b0, fill_reg});
            quo[l]     = neg_reg[l] ? (~dq_reg[l] + 1'b1) : dq_reg[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    state_next = (item.cmd == CMD_START) ? ST_EVICT_CHK : ST_MUL_A;
                end
            end
            ST_MUL_A: state_next = ST_ADD_V;
            ST_ADD_V: state_next = ST_MUL_K;
            ST_MUL_K: state_next = ST_UPD;
            ST_UPD:   state_next = ST_EVICT_CHK;
            ST_EVICT_CHK:
            begin
                if (need_evict)
                begin
                    ram_re     = 1'b1;
                    state_next = ST_EVICT_SUB;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_EVICT_SUB: state_next = ST_EVICT_CHK;
            ST_PUSH:
            begin
                ram_we     = 1'b1;
                state_next = start_reg ? ST_DONE : ST_DIV_SETUP;
            end
            ST_DIV_SETUP: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_cnt_reg == DCNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < 2; l++)
            begin
                pos_reg[l] <= '0;
                vel_reg[l] <= '0;
                sum_reg[l] <= '0;
            end
            fill_reg      <= '0;
            head_reg      <= '0;
            div_cnt_reg   <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        start_reg <= (item.cmd == CMD_START);
                        if (item.cmd == CMD_START)
                        begin
                            pos_reg[0] <= item.pt_x;
                            pos_reg[1] <= item.pt_y;
                            for (int l = 0; l < 2; l++)
                            begin
                                vel_reg[l] <= '0;
                                sum_reg[l] <= '0;
                            end
                            fill_reg <= '0;
                            head_reg <= '0;
                        end
                    end
                end
                ST_UPD:
                begin
                    for (int l = 0; l < 2; l++)
                    begin
                        vel_reg[l] <= vel_new[l];
                        pos_reg[l] <= pos_new[l];
                    end
                end
                ST_EVICT_SUB:
                begin
                    for (int l = 0; l < 2; l++)
                    begin
                        sum_reg[l] <= sum_reg[l] - SUM_W'(rd_crd[l]);
                    end
                    head_reg <= (head_reg == IDX_W'(WINDOW_MAX - 1)) ? '0 : head_reg + 1'b1;
                    fill_reg <= fill_reg - 1'b1;
                end
                ST_PUSH:
                begin
                    for (int l = 0; l < 2; l++)
                    begin
                        sum_reg[l] <= sum_reg[l] + SUM_W'(pos_reg[l]);
                    end
                    fill_reg <= fill_reg + 1'b1;
                end
                ST_DIV_SETUP: div_cnt_reg <= DCNT_W'(SUM_W);
                ST_DIV:       div_cnt_reg <= div_cnt_reg - 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    pt_reg[0] <= item.pt_x;
                    pt_reg[1] <= item.pt_y;
                end
            end
            ST_MUL_A:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    prod_a_reg[l] <= 42'(mag_a[l]) * 42'(cfg.mass_recip);
                    neg_reg[l]    <= diff_a[l][COORD_W];
                end
            end
            ST_ADD_V:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    mag_b_reg[l] <= mag_b[l];
                    neg_reg[l]   <= sum_v[l][32];
                end
            end
            ST_MUL_K:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    prod_k_reg[l] <= 50'(mag_b_reg[l]) * 50'(cfg.drag_keep);
                end
            end
            ST_DIV_SETUP:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    dq_reg[l]  <= sum_mag[l];
                    rem_reg[l] <= '0;
                    neg_reg[l] <= sum_reg[l][SUM_W-1];
                end
            end
            // restoring divide by the fill count, one quotient bit per cycle
            ST_DIV:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    dq_reg[l]  <= {dq_reg[l][SUM_W-2:0], q_bit[l]};
                    rem_reg[l] <= q_bit[l] ? CNT_W'(rem_sh[l] - {1'b0, fill_reg})
                                           : CNT_W'(rem_sh[l]);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_reg.out_x <= start_reg ? pos_reg[0] : quo[0][COORD_W-1:0];
                    out_data_reg.out_y <= start_reg ? pos_reg[1] : quo[1][COORD_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW_MAX))
        else $error("window fill beyond capacity");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (fill_reg != '0))
        else $error("mean taken over an empty window");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH) |=> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("window push did not add an entry");

endmodule

### rtl/stroke_inertia_average_filter.sv
// Pen stroke smoother: a start word loads the position, clears velocity and the averaging
// window and echoes the point. A point word runs one damped inertia step on both axes,
// evicts old window entries (normally one entry), writes the new position into the
// window memory, and divides the running sums by the fill count in a bit-serial divider
// over the 24 + log2(WINDOW_MAX)-bit sums. The divider sets the rate. A two-word input
// queue lets the port keep accepting while a word is in work, and the result sits in an
// output register until taken. Configuration is written through cfg_wr_en/cfg_index/
// cfg_data; the user must write it only while the filter is idle, which the block itself
// does not enforce. Gains above 1.0 act as 1.0 and the window length is limited to
// 1..WINDOW_MAX.
module stroke_inertia_average_filter
    import sia_pkg::*;
#(
    parameter int WINDOW_MAX = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sia_in_t              in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sia_out_t             out_data
);

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    logic             push_valid;
    logic             push_ready;
    sia_item_t        push_item;
    logic             pop_valid;
    logic             pop_ready;
    sia_item_t        pop_item;
    sia_cfg_t         cfg;
    logic [CNT_W-1:0] win_len;

    sia_front #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .cfg        (cfg),
        .win_len    (win_len)
    );

    sia_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    sia_back #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (pop_valid),
        .item_ready (pop_ready),
        .item       (pop_item),
        .cfg        (cfg),
        .win_len    (win_len),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

### tb/tb_stroke_inertia_average_filter.sv
module tb_stroke_inertia_average_filter;
    import sia_pkg::*;

    localparam int WIN_MAX = 16;
    localparam int SEGMENTS = 14;
    localparam int SEG_WORDS = 125;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 64;

    localparam sia_coord_t CMAX = 24'sh7fffff;
    localparam sia_coord_t CMIN = 24'sh800000;
    localparam longint POS_HI = 64'sd8388607;
    localparam longint POS_LO = -64'sd8388608;
    localparam longint VEL_HI = 64'sd2147483647;
    localparam longint VEL_LO = -64'sd2147483648;
    localparam longint GAIN_ONE = 64'sd65536;

    typedef enum logic {
        ROW_WORD,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        sia_in_t              word;
        logic                 pinned;
        sia_out_t             result;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
    } row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    sia_in_t              in_data;
    logic                 out_valid;
    logic                 out_ready;
    sia_out_t             out_data;

    // filter state mirrored for prediction
    logic [CFG_W-1:0] mass_q;
    logic [CFG_W-1:0] drag_q;
    logic [LEN_W-1:0] len_q;
    longint           pos_q [2];
    longint           vel_q [2];
    longint           win_q [2][WIN_MAX];
    longint           sum_q [2];
    int               fill_q;
    int               head_q;

    sia_out_t smoothed_q [$];
    sia_out_t want_word;
    sia_out_t got_word;
    logic     pin_on;
    sia_out_t pin_val;
    int       mismatches = 0;
    int       src_idle_pct = 0;
    int       sink_stall_pct = 0;
    row_t     stim_rows [26];

    stroke_inertia_average_filter #(
        .WINDOW_MAX(WIN_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // magnitude * k / 65536, rounded half away from zero
    function automatic longint scale_q16(input longint a, input longint k);
        longint mag;
        mag = (a < 0) ? -a : a;
        mag = (mag * k + 32768) >>> 16;
        return (a < 0) ? -mag : mag;
    endfunction

    function automatic sia_out_t predict_smoothed(input sia_in_t w);
        longint   pt [2];
        longint   m;
        longint   k;
        longint   v;
        int       len;
        int       slot;
        sia_out_t r;
        pt[0] = w.pt_x;
        pt[1] = w.pt_y;
        len = (len_q == 0) ? 1 : ((len_q > WIN_MAX) ? WIN_MAX : int'(len_q));
        m = (longint'(mass_q) > GAIN_ONE) ? GAIN_ONE : longint'(mass_q);
        k = (longint'(drag_q) > GAIN_ONE) ? GAIN_ONE : longint'(drag_q);
        if (w.req_type == REQ_START)
        begin
            fill_q = 0;
            head_q = 0;
            for (int a = 0; a < 2; a++)
            begin
                pos_q[a] = pt[a];
                vel_q[a] = 0;
                sum_q[a] = 0;
            end
        end
        else
        begin
            for (int a = 0; a < 2; a++)
            begin
                v = scale_q16(vel_q[a] + scale_q16(pt[a] - pos_q[a], m), k);
                v = (v > VEL_HI) ? VEL_HI : ((v < VEL_LO) ? VEL_LO : v);
                vel_q[a] = v;
                pos_q[a] = pos_q[a] + v;
                pos_q[a] = (pos_q[a] > POS_HI) ? POS_HI :
                           ((pos_q[a] < POS_LO) ? POS_LO : pos_q[a]);
            end
        end
        // evict oldest entries until the new one fits
        while (fill_q >= len)
        begin
            for (int a = 0; a < 2; a++)
                sum_q[a] -= win_q[a][head_q];
            head_q = (head_q + 1) % WIN_MAX;
            fill_q--;
        end
        slot = (head_q + fill_q) % WIN_MAX;
        for (int a = 0; a < 2; a++)
        begin
            win_q[a][slot] = pos_q[a];
            sum_q[a] += pos_q[a];
        end
        fill_q++;
        r.out_x = sia_coord_t'(sum_q[0] / fill_q);
        r.out_y = sia_coord_t'(sum_q[1] / fill_q);
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got_word = out_data;
                if (smoothed_q.size() == 0)
                    report_mismatch("unexpected word, out_x", got_word.out_x, 0);
                else
                begin
                    want_word = smoothed_q.pop_front();
                    if (got_word.out_x !== want_word.out_x)
                        report_mismatch("out_x", got_word.out_x, want_word.out_x);
                    if (got_word.out_y !== want_word.out_y)
                        report_mismatch("out_y", got_word.out_y, want_word.out_y);
                end
            end
            if (in_valid && in_ready)
            begin
                want_word = predict_smoothed(in_data);
                smoothed_q.insert(smoothed_q.size(), pin_on ? pin_val : want_word);
            end
        end
    end

    function automatic row_t word_row(input logic cmd, input sia_coord_t x, input sia_coord_t y);
        row_t r;
        r = '0;
        r.kind = ROW_WORD;
        r.word.req_type = cmd;
        r.word.pt_x = x;
        r.word.pt_y = y;
        return r;
    endfunction

    function automatic row_t pinned_row(input logic cmd, input sia_coord_t x, input sia_coord_t y,
                                        input sia_coord_t ex, input sia_coord_t ey);
        row_t r;
        r = word_row(cmd, x, y);
        r.pinned = 1'b1;
        r.result.out_x = ex;
        r.result.out_y = ey;
        return r;
    endfunction

    function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        row_t r;
        r = '0;
        r.kind = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic logic [CFG_W-1:0] pick_gain();
        case ($urandom_range(9))
            0: return '0;
            1: return 17'd1;
            2: return 17'd65535;
            3: return Q16_ONE;
            4: return 17'h1ffff;
            5: return CFG_W'($urandom_range(131071, 65537));
            default: return CFG_W'($urandom_range(65536));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_len();
        case ($urandom_range(9))
            0: return '0;
            1: return 17'd1;
            2: return 17'd16;
            3: return 17'd31;
            4: return CFG_W'($urandom_range(30, 17));
            default: return CFG_W'($urandom_range(15, 2));
        endcase
    endfunction

    function automatic sia_coord_t next_coord(input sia_coord_t prev);
        longint c;
        case ($urandom_range(19))
            15, 16: return sia_coord_t'($urandom);
            17: return CMAX;
            18: return CMIN;
            19: return $urandom_range(1) ? sia_coord_t'(0) : sia_coord_t'(-1);
            default:
            begin
                c = prev + longint'($urandom_range(8191)) - 4096;
                c = (c > POS_HI) ? POS_HI : ((c < POS_LO) ? POS_LO : c);
                return sia_coord_t'(c);
            end
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input sia_in_t w, input logic pinned, input sia_out_t want);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        pin_on <= pinned;
        pin_val <= want;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic settle();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (smoothed_q.size() > 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (smoothed_q.size() > 0)
        begin
            report_mismatch("words never delivered", 0, smoothed_q.size());
            smoothed_q.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_wr_en <= 1'b1;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        case (idx)
            CFG_MASS_RECIP: mass_q = val;
            CFG_DRAG_KEEP: drag_q = val;
            CFG_WINDOW_LEN: len_q = val[LEN_W-1:0];
            default: ;
        endcase
    endtask

    initial
    begin
        int         left;
        sia_in_t    w;
        sia_coord_t last_x;
        sia_coord_t last_y;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_MASS_RECIP;
        cfg_data = '0;
        pin_on = 1'b0;
        pin_val = '0;
        mass_q = MASS_RECIP_RST;
        drag_q = DRAG_KEEP_RST;
        len_q = WINDOW_LEN_RST;
        fill_q = 0;
        head_q = 0;
        for (int a = 0; a < 2; a++)
        begin
            pos_q[a] = 0;
            vel_q[a] = 0;
            sum_q[a] = 0;
        end
        left = 0;
        last_x = '0;
        last_y = '0;

        stim_rows = '{
            // points before any start run from the reset state
            word_row(CMD_POINT, CMAX, CMIN),
            word_row(CMD_POINT, CMIN, CMAX),
            pinned_row(CMD_START, CMIN, CMAX, CMIN, CMAX),
            pinned_row(CMD_START, CMAX, CMIN, CMAX, CMIN),
            pinned_row(CMD_START, 0, 0, 0, 0),
            pinned_row(CMD_START, 1000, -1000, 1000, -1000),
            pinned_row(CMD_POINT, 1000, -1000, 1000, -1000),
            word_row(CMD_POINT, -1, -1),
            word_row(CMD_POINT, CMAX, CMAX),
            word_row(CMD_POINT, CMAX, CMAX),
            word_row(CMD_POINT, CMIN, 0),
            word_row(CMD_POINT, CMIN, CMIN),
            word_row(CMD_POINT, 12345, -54321),
            word_row(CMD_POINT, CMAX, CMIN),
            word_row(CMD_POINT, 1, 1),
            // shrink the window in the middle of a stroke
            reg_row(CFG_WINDOW_LEN, 17'd2),
            word_row(CMD_POINT, 0, 0),
            // gains above one act as one, length zero acts as one
            reg_row(CFG_MASS_RECIP, 17'h1ffff),
            reg_row(CFG_DRAG_KEEP, 17'h1ffff),
            reg_row(CFG_WINDOW_LEN, 17'd0),
            pinned_row(CMD_START, CMIN, CMIN, CMIN, CMIN),
            pinned_row(CMD_POINT, CMAX, CMAX, CMAX, CMAX),
            pinned_row(CMD_POINT, CMAX, CMAX, CMAX, CMAX),
            reg_row(CFG_MASS_RECIP, 17'd0),
            reg_row(CFG_WINDOW_LEN, 17'd31),
            word_row(CMD_POINT, CMIN, 5)
        };

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_REG)
            begin
                settle();
                write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
            end
            else
                send_word(stim_rows[i].word, stim_rows[i].pinned, stim_rows[i].result);
        end

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            settle();
            write_reg(CFG_MASS_RECIP, pick_gain());
            write_reg(CFG_DRAG_KEEP, pick_gain());
            write_reg(CFG_WINDOW_LEN, pick_len());
            case (seg % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 60; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 60; end
                default: begin src_idle_pct = 31; sink_stall_pct = 31; end
            endcase
            // strokes run on across segments, so a new setting can hit mid-stroke
            for (int n = 0; n < SEG_WORDS; n++)
            begin
                if (left == 0)
                begin
                    if ($urandom_range(9) == 0)
                        w.req_type = CMD_POINT;
                    else
                    begin
                        w.req_type = CMD_START;
                        left = $urandom_range(40, 1);
                    end
                end
                else
                begin
                    w.req_type = CMD_POINT;
                    left--;
                end
                w.pt_x = next_coord(last_x);
                w.pt_y = next_coord(last_y);
                last_x = w.pt_x;
                last_y = w.pt_y;
                send_word(w, 1'b0, '0);
            end
        end

        settle();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
rtl/sia_pkg.sv
rtl/sia_ram.sv
rtl/sia_fifo.sv
rtl/sia_front.sv
rtl/sia_back.sv
rtl/stroke_inertia_average_filter.sv
tb/tb_stroke_inertia_average_filter.sv
